### rtl/core/hdsrpt_pkg.sv
// Shared types, constants and helpers of the deficit/SRPT scheduler.
package hdsrpt_pkg;

  localparam int NUM_RECEIVERS = 16;
  localparam int DEFICIT_BITS  = 24;
  localparam int FRAC_BITS     = 16;
  localparam int IDX_W         = (NUM_RECEIVERS > 1) ? $clog2(NUM_RECEIVERS) : 1;
  localparam int COUNT_W       = $clog2(NUM_RECEIVERS + 1);
  localparam int WEIGHT_W      = 17;
  localparam int QUANTUM_W     = 18;
  localparam int ROUNDS_W      = 17;
  localparam int PROD_W        = ROUNDS_W + QUANTUM_W;
  localparam int DIV_STEPS     = 17;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [DEFICIT_BITS-1:0] ONE_FX  = DEFICIT_BITS'(1) << FRAC_BITS;
  localparam logic [DEFICIT_BITS-1:0] DEF_MAX = '1;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FAIR_WEIGHT   = 2'd0,
    REG_SRPT_WEIGHT   = 2'd1,
    REG_PRIORITY_MODE = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                    sendable;
    logic [31:0]             credit;
    logic [31:0]             unsent;
    logic [DEFICIT_BITS-1:0] deficit;
    logic [QUANTUM_W-1:0]    quantum;
    logic                    srpt_flag;
  } slot_t;

  typedef struct packed {
    logic        sendable;
    logic [31:0] credit;
    logic [31:0] unsent;
  } report_t;

  typedef struct packed {
    logic                 start;
    logic [WEIGHT_W-1:0]  dividend;
    logic [QUANTUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ROUNDS_W-1:0] quotient;
    logic                rem_nz;
  } div_rsp_t;

  function automatic logic [DEFICIT_BITS-1:0] sat_add(
    input logic [DEFICIT_BITS-1:0] d,
    input logic [PROD_W-1:0]       add
  );
    logic [PROD_W+DEFICIT_BITS:0] s;
    s = (PROD_W+DEFICIT_BITS+1)'(d) + (PROD_W+DEFICIT_BITS+1)'(add);
    if (s > (PROD_W+DEFICIT_BITS+1)'(DEF_MAX)) begin
      return DEF_MAX;
    end
    return DEFICIT_BITS'(s);
  endfunction

endpackage

### rtl/core/hdsrpt_cell.sv
// One receiver slot of the shift ring: holds its state, passes it on when shifted.
module hdsrpt_cell import hdsrpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift_en,
  input  slot_t   shift_in,
  input  logic    rep_en,
  input  report_t rep,
  output slot_t   slot_q
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (rep_en) begin
      slot_nxt.sendable = rep.sendable;
      slot_nxt.credit   = rep.credit;
      slot_nxt.unsent   = rep.unsent;
      // drop accumulated service of a receiver that went idle
      if (!rep.sendable) begin
        slot_nxt.deficit = '0;
        slot_nxt.quantum = '0;
      end
    end else if (shift_en) begin
      slot_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule

### rtl/core/hdsrpt_div.sv
// Restoring divider, one quotient bit per cycle, shared by update and select.
module hdsrpt_div import hdsrpt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [QUANTUM_W-1:0] rem_r, rem_nxt;
  logic [ROUNDS_W-1:0]  quo_r, quo_nxt;
  logic [QUANTUM_W-1:0] dsr_r, dsr_nxt;
  logic                 done_r, done_nxt;
  logic [QUANTUM_W:0]   trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[ROUNDS_W-1]};
    if (req.start) begin
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
      rem_nxt = '0;
      quo_nxt = ROUNDS_W'(req.dividend);
      dsr_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = QUANTUM_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[ROUNDS_W-2:0], 1'b1};
      end else begin
        rem_nxt = QUANTUM_W'(trial);
        quo_nxt = {quo_r[ROUNDS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.rem_nz   = (rem_r != '0);

endmodule

### rtl/core/hybrid_deficit_srpt_scheduler.sv
// Deficit scheduler with SRPT weighting: sequencer, slot ring and shared divider.
// Report and no-op: result strobe in the cycle after start. Update: a count scan over
// the slots, a divide wait and an apply pass (it ends after the scan if none is sendable).
// Select: a max scan plus a charge pass; when a refill is needed add a rounds pass with
// a divide per sendable slot of nonzero quantum, then a refill pass before the charge.
// One command at a time, results never stall; sync reset clears slots, loads defaults.
module hybrid_deficit_srpt_scheduler import hdsrpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_receiver,
  input  logic        in_sendable,
  input  logic [31:0] in_credit_bytes,
  input  logic [31:0] in_unsent_bytes,
  output logic        out_valid,
  output logic        out_winner_valid,
  output logic [3:0]  out_winner,
  output logic        out_winner_is_srpt_flow,
  output logic [4:0]  out_sendable_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD_SCAN, ST_UPD_DIV, ST_UPD_APPLY,
    ST_SEL_SCAN, ST_SEL_RND, ST_SEL_REFILL, ST_SEL_CHARGE
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RECEIVERS - 1);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]   last_count_r, last_count_nxt;
  logic [IDX_W-1:0]     prio_r, prio_nxt;
  logic [31:0]          prio_key_r, prio_key_nxt;
  logic [IDX_W-1:0]     flow_r, flow_nxt;
  logic [31:0]          flow_key_r, flow_key_nxt;
  logic [WEIGHT_W-1:0]  low_r, low_nxt;
  logic                 any_r, any_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [DEFICIT_BITS-1:0] best_def_r, best_def_nxt;
  logic                 best_flag_r, best_flag_nxt;
  logic                 wait_r, wait_nxt;
  logic [ROUNDS_W-1:0]  rounds_r, rounds_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 win_valid_r, win_valid_nxt;
  logic [IDX_W-1:0]     win_r, win_nxt;
  logic                 win_flag_r, win_flag_nxt;

  logic [WEIGHT_W-1:0]  fair_weight_r;
  logic [WEIGHT_W-1:0]  srpt_weight_r;
  logic                 priority_mode_r;

  slot_t    slot_q [NUM_RECEIVERS];
  slot_t    head;
  slot_t    tail_in;
  logic     shift_en;
  logic     rep_valid;
  report_t  rep;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [QUANTUM_W-1:0]    high_q;
  logic [QUANTUM_W-1:0]    q_sel;
  logic [ROUNDS_W-1:0]     k_val;
  logic [PROD_W-1:0]       refill_add;
  logic [DEFICIT_BITS-1:0] new_def;
  logic                    adv;
  logic                    cfg_wr;
  reg_idx_t                cfg_reg;

  // slot ring
  for (genvar k = 0; k < NUM_RECEIVERS; k++) begin : g_cell
    hdsrpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .shift_in ((k == NUM_RECEIVERS - 1) ? tail_in : slot_q[(k + 1) % NUM_RECEIVERS]),
      .rep_en   (rep_valid && (32'(in_receiver) == k)),
      .rep      (rep),
      .slot_q   (slot_q[k])
    );
  end

  hdsrpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign head           = slot_q[0];
  assign rep.sendable   = in_sendable;
  assign rep.credit     = in_credit_bytes;
  assign rep.unsent     = in_unsent_bytes;
  assign high_q         = {1'b0, low_r} + {1'b0, srpt_weight_r};
  assign q_sel          = (idx_r == prio_r) ? high_q : {1'b0, low_r};
  assign k_val          = div_rsp.quotient + ROUNDS_W'(div_rsp.rem_nz);
  assign refill_add     = PROD_W'(rounds_r) * PROD_W'(head.quantum);
  assign new_def        = sat_add(head.deficit, refill_add);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    last_count_nxt = last_count_r;
    prio_nxt       = prio_r;
    prio_key_nxt   = prio_key_r;
    flow_nxt       = flow_r;
    flow_key_nxt   = flow_key_r;
    low_nxt        = low_r;
    any_nxt        = any_r;
    best_nxt       = best_r;
    best_def_nxt   = best_def_r;
    best_flag_nxt  = best_flag_r;
    wait_nxt       = wait_r;
    rounds_nxt     = rounds_r;
    out_valid_nxt  = 1'b0;
    win_valid_nxt  = win_valid_r;
    win_nxt        = win_r;
    win_flag_nxt   = win_flag_r;
    shift_en       = 1'b0;
    tail_in        = head;
    rep_valid      = 1'b0;
    adv            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = fair_weight_r;
    div_req.divisor  = QUANTUM_W'(cnt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_command))
            CMD_REPORT: begin
              rep_valid     = (32'(in_receiver) < NUM_RECEIVERS);
              out_valid_nxt = 1'b1;
              win_valid_nxt = 1'b0;
              win_nxt       = '0;
              win_flag_nxt  = 1'b0;
            end
            CMD_UPDATE: begin
              state_nxt = ST_UPD_SCAN;
              idx_nxt   = '0;
              cnt_nxt   = '0;
            end
            CMD_SELECT: begin
              state_nxt = ST_SEL_SCAN;
              idx_nxt   = '0;
              any_nxt   = 1'b0;
            end
            CMD_NOP: begin
              out_valid_nxt = 1'b1;
              win_valid_nxt = 1'b0;
              win_nxt       = '0;
              win_flag_nxt  = 1'b0;
            end
          endcase
        end
      end

      ST_UPD_SCAN: begin
        adv = 1'b1;
        if (head.sendable) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == '0 ||
              (priority_mode_r ? (head.credit > prio_key_r) : (head.unsent < prio_key_r))) begin
            prio_nxt     = idx_r;
            prio_key_nxt = priority_mode_r ? head.credit : head.unsent;
          end
          if (cnt_r == '0 || head.unsent < flow_key_r) begin
            flow_nxt     = idx_r;
            flow_key_nxt = head.unsent;
          end
        end
        if (idx_r == LAST_IDX) begin
          if (cnt_nxt == '0) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            win_valid_nxt = 1'b0;
            win_nxt       = '0;
            win_flag_nxt  = 1'b0;
          end else begin
            state_nxt       = ST_UPD_DIV;
            div_req.start   = 1'b1;
            div_req.divisor = QUANTUM_W'(cnt_nxt);
          end
        end
      end

      ST_UPD_DIV: begin
        if (div_rsp.done) begin
          low_nxt   = div_rsp.quotient;
          state_nxt = ST_UPD_APPLY;
        end
      end

      ST_UPD_APPLY: begin
        adv = 1'b1;
        if (head.sendable) begin
          tail_in.quantum   = q_sel;
          tail_in.deficit   = sat_add(head.deficit, PROD_W'(q_sel));
          tail_in.srpt_flag = (idx_r == flow_r);
        end
        if (idx_r == LAST_IDX) begin
          last_count_nxt = cnt_r;
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          win_valid_nxt  = 1'b0;
          win_nxt        = '0;
          win_flag_nxt   = 1'b0;
        end
      end

      ST_SEL_SCAN: begin
        adv = 1'b1;
        if (head.sendable && (!any_r || head.deficit > best_def_r)) begin
          best_nxt      = idx_r;
          best_def_nxt  = head.deficit;
          best_flag_nxt = head.srpt_flag;
          any_nxt       = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          if (!any_nxt) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            win_valid_nxt = 1'b0;
            win_nxt       = '0;
            win_flag_nxt  = 1'b0;
          end else if (best_def_nxt >= ONE_FX) begin
            state_nxt = ST_SEL_CHARGE;
          end else begin
            state_nxt = ST_SEL_RND;
            any_nxt   = 1'b0;
            wait_nxt  = 1'b0;
          end
        end
      end

      ST_SEL_RND: begin
        if (!wait_r) begin
          if (head.sendable && head.quantum != '0) begin
            // hold the ring while the divider works out this slot's rounds
            div_req.start    = 1'b1;
            div_req.dividend = WEIGHT_W'(ONE_FX - head.deficit);
            div_req.divisor  = head.quantum;
            wait_nxt         = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end else if (div_rsp.done) begin
          wait_nxt = 1'b0;
          adv      = 1'b1;
          if (!any_r || k_val < rounds_r) begin
            rounds_nxt = k_val;
          end
          any_nxt = 1'b1;
        end
        if (adv && idx_r == LAST_IDX) begin
          if (!any_nxt) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            win_valid_nxt = 1'b0;
            win_nxt       = '0;
            win_flag_nxt  = 1'b0;
          end else begin
            state_nxt = ST_SEL_REFILL;
            any_nxt   = 1'b0;
          end
        end
      end

      ST_SEL_REFILL: begin
        adv = 1'b1;
        if (head.sendable) begin
          tail_in.deficit = new_def;
          if (!any_r || new_def > best_def_r) begin
            best_nxt      = idx_r;
            best_def_nxt  = new_def;
            best_flag_nxt = head.srpt_flag;
            any_nxt       = 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_SEL_CHARGE;
        end
      end

      ST_SEL_CHARGE: begin
        adv = 1'b1;
        if (idx_r == best_r) begin
          tail_in.deficit = head.deficit - ONE_FX;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          win_valid_nxt = 1'b1;
          win_nxt       = best_r;
          win_flag_nxt  = best_flag_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (adv) begin
      shift_en = 1'b1;
      idx_nxt  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      cnt_r        <= '0;
      last_count_r <= '0;
      any_r        <= 1'b0;
      wait_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      win_valid_r  <= 1'b0;
      win_r        <= '0;
      win_flag_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      last_count_r <= last_count_nxt;
      any_r        <= any_nxt;
      wait_r       <= wait_nxt;
      out_valid_r  <= out_valid_nxt;
      win_valid_r  <= win_valid_nxt;
      win_r        <= win_nxt;
      win_flag_r   <= win_flag_nxt;
    end
    prio_r      <= prio_nxt;
    prio_key_r  <= prio_key_nxt;
    flow_r      <= flow_nxt;
    flow_key_r  <= flow_key_nxt;
    low_r       <= low_nxt;
    best_r      <= best_nxt;
    best_def_r  <= best_def_nxt;
    best_flag_r <= best_flag_nxt;
    rounds_r    <= rounds_nxt;
  end

  // configuration registers
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fair_weight_r   <= WEIGHT_W'(32768);
      srpt_weight_r   <= WEIGHT_W'(32768);
      priority_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_FAIR_WEIGHT:   fair_weight_r   <= pwdata[WEIGHT_W-1:0];
        REG_SRPT_WEIGHT:   srpt_weight_r   <= pwdata[WEIGHT_W-1:0];
        REG_PRIORITY_MODE: priority_mode_r <= pwdata[0];
        REG_NONE:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_FAIR_WEIGHT:   prdata = 32'(fair_weight_r);
      REG_SRPT_WEIGHT:   prdata = 32'(srpt_weight_r);
      REG_PRIORITY_MODE: prdata = 32'(priority_mode_r);
      REG_NONE:          prdata = '0;
    endcase
  end

  assign pready                  = 1'b1;
  assign busy                    = (state_r != ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_winner_valid        = win_valid_r;
  assign out_winner              = 4'(win_r);
  assign out_winner_is_srpt_flow = win_flag_r;
  assign out_sendable_count      = 5'(last_count_r);

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("multi-cycle command finished without a result word");

  a_no_word_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result word while a command is in flight");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_winner_valid) |-> (out_winner == 4'd0 && !out_winner_is_srpt_flow))
    else $error("result word without winner carries winner fields");

endmodule

### bench/hybrid_deficit_srpt_scheduler_test.sv
// Self-checking bench for the deficit/SRPT scheduler: directed table, then random traffic.
`timescale 1ns / 100ps
module hybrid_deficit_srpt_scheduler_test import hdsrpt_pkg::*; ();

  localparam int LIMIT_CYCLES = 1000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [3:0]  in_receiver;
  logic        in_sendable;
  logic [31:0] in_credit_bytes;
  logic [31:0] in_unsent_bytes;
  logic        out_valid;
  logic        out_winner_valid;
  logic [3:0]  out_winner;
  logic        out_winner_is_srpt_flow;
  logic [4:0]  out_sendable_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hybrid_deficit_srpt_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_receiver(in_receiver), .in_sendable(in_sendable),
    .in_credit_bytes(in_credit_bytes), .in_unsent_bytes(in_unsent_bytes),
    .out_valid(out_valid), .out_winner_valid(out_winner_valid), .out_winner(out_winner),
    .out_winner_is_srpt_flow(out_winner_is_srpt_flow),
    .out_sendable_count(out_sendable_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic       winner_valid;
    logic [3:0] winner;
    logic       srpt_flow;
    logic [4:0] count;
  } decision_t;

  // mirrored scheduler state
  logic [16:0]             fair_w;
  logic [16:0]             srpt_w;
  logic                    credit_mode;
  logic                    sl_send  [NUM_RECEIVERS];
  logic [31:0]             sl_cred  [NUM_RECEIVERS];
  logic [31:0]             sl_unsent[NUM_RECEIVERS];
  logic [DEFICIT_BITS-1:0] sl_def   [NUM_RECEIVERS];
  logic [17:0]             sl_quant [NUM_RECEIVERS];
  logic                    sl_flow  [NUM_RECEIVERS];
  logic [4:0]              active_count;

  decision_t pending_decisions[$];
  int        errors;
  int        cycle_count;
  int        send_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [DEFICIT_BITS-1:0] add_saturated(logic [DEFICIT_BITS-1:0] d,
                                                             logic [63:0] add);
    logic [63:0] s;
    s = 64'(d) + add;
    return (s > 64'(DEF_MAX)) ? DEF_MAX : s[DEFICIT_BITS-1:0];
  endfunction

  task automatic mirror_reset();
    fair_w = 17'd32768;
    srpt_w = 17'd32768;
    credit_mode = 1'b0;
    active_count = '0;
    for (int i = 0; i < NUM_RECEIVERS; i++) begin
      sl_send[i] = 0; sl_cred[i] = 0; sl_unsent[i] = 0;
      sl_def[i] = 0; sl_quant[i] = 0; sl_flow[i] = 0;
    end
  endtask

  function automatic int largest_deficit();
    int best;
    best = -1;
    for (int i = 0; i < NUM_RECEIVERS; i++)
      if (sl_send[i] && (best < 0 || sl_def[i] > sl_def[best])) best = i;
    return best;
  endfunction

  function automatic decision_t schedule_step(logic [1:0] cmd, logic [3:0] rx, logic snd,
                                              logic [31:0] cred, logic [31:0] uns);
    decision_t r;
    int cnt, prio, flow, best;
    logic [31:0] low, high;
    logic [63:0] rounds, need, k;
    logic any;
    r = '0;
    if (cmd == CMD_REPORT) begin
      sl_send[rx] = snd; sl_cred[rx] = cred; sl_unsent[rx] = uns;
      if (!snd) begin
        sl_def[rx] = 0; sl_quant[rx] = 0;
      end
    end else if (cmd == CMD_UPDATE) begin
      cnt = 0; prio = -1; flow = -1;
      for (int i = 0; i < NUM_RECEIVERS; i++) begin
        if (!sl_send[i]) continue;
        cnt++;
        if (prio < 0) prio = i;
        else if (credit_mode) begin
          if (sl_cred[i] > sl_cred[prio]) prio = i;
        end else if (sl_unsent[i] < sl_unsent[prio]) prio = i;
        if (flow < 0 || sl_unsent[i] < sl_unsent[flow]) flow = i;
      end
      if (cnt > 0) begin
        active_count = 5'(cnt);
        low = 32'(fair_w) / 32'(cnt);
        high = low + 32'(srpt_w);
        for (int i = 0; i < NUM_RECEIVERS; i++) begin
          if (!sl_send[i]) continue;
          sl_quant[i] = (i == prio) ? high[17:0] : low[17:0];
          sl_def[i] = add_saturated(sl_def[i], 64'(sl_quant[i]));
          sl_flow[i] = (i == flow);
        end
      end
    end else if (cmd == CMD_SELECT) begin
      best = largest_deficit();
      if (best >= 0 && sl_def[best] < ONE_FX) begin
        rounds = 0; any = 0;
        for (int i = 0; i < NUM_RECEIVERS; i++) begin
          if (!sl_send[i] || sl_quant[i] == 0) continue;
          need = 64'(ONE_FX) - 64'(sl_def[i]);
          k = (need + 64'(sl_quant[i]) - 1) / 64'(sl_quant[i]);
          if (!any || k < rounds) rounds = k;
          any = 1;
        end
        if (!any) best = -1;
        else begin
          for (int i = 0; i < NUM_RECEIVERS; i++)
            if (sl_send[i]) sl_def[i] = add_saturated(sl_def[i], rounds * 64'(sl_quant[i]));
          best = largest_deficit();
        end
      end
      if (best >= 0) begin
        sl_def[best] = sl_def[best] - ONE_FX;
        r.winner_valid = 1; r.winner = 4'(best); r.srpt_flow = sl_flow[best];
      end
    end
    r.count = active_count;
    return r;
  endfunction

  // results: the receiver cannot stall, so check every strobed word
  always @(posedge clk) begin
    decision_t exp_d;
    if (rst_n && out_valid) begin
      if (pending_decisions.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        exp_d = pending_decisions.pop_front();
        if (out_winner_valid !== exp_d.winner_valid) begin
          $error("winner_valid exp %0d got %0d", exp_d.winner_valid, out_winner_valid);
          errors++;
        end
        if (out_winner !== exp_d.winner) begin
          $error("winner exp %0d got %0d", exp_d.winner, out_winner);
          errors++;
        end
        if (out_winner_is_srpt_flow !== exp_d.srpt_flow) begin
          $error("winner_is_srpt_flow exp %0d got %0d", exp_d.srpt_flow,
                 out_winner_is_srpt_flow);
          errors++;
        end
        if (out_sendable_count !== exp_d.count) begin
          $error("sendable_count exp %0d got %0d", exp_d.count, out_sendable_count);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_FAIR_WEIGHT: fair_w = val[16:0];
      REG_SRPT_WEIGHT: srpt_w = val[16:0];
      REG_PRIORITY_MODE: credit_mode = val[0];
      default: ;
    endcase
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (pending_decisions.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // issue one word; optionally check a hand-computed result too
  task automatic issue(logic [1:0] cmd, logic [3:0] rx, logic snd, logic [31:0] cred,
                       logic [31:0] uns, logic has_fixed, decision_t fixed);
    decision_t d;
    logic idle;
    idle = (send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct);
    if (idle) start <= 0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    start <= 1; in_command <= cmd; in_receiver <= rx; in_sendable <= snd;
    in_credit_bytes <= cred; in_unsent_bytes <= uns;
    @(posedge clk);
    while (busy) @(posedge clk);
    d = schedule_step(cmd, rx, snd, cred, uns);
    if (has_fixed && d !== fixed) begin
      $error("directed row: fixed result %h predictor %h", fixed, d);
      errors++;
    end
    pending_decisions = {pending_decisions, d};
  endtask

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  rx;
    logic        snd;
    logic [31:0] cred;
    logic [31:0] uns;
    logic        has_fixed;
    decision_t   fixed;
  } table_row_t;

  table_row_t directed_rows[] = '{
    '{CMD_SELECT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
    '{CMD_UPDATE, 4'd0, 1'b0, 32'd0, 32'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
    '{CMD_NOP, 4'd15, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
    '{CMD_REPORT, 4'd0, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '0},
    '{CMD_REPORT, 4'd15, 1'b1, 32'd0, 32'd0, 1'b1, '0},
    '{CMD_REPORT, 4'd7, 1'b1, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_SELECT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_UPDATE, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_SELECT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_SELECT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_REPORT, 4'd7, 1'b0, 32'h5555AAAA, 32'hAAAA5555, 1'b0, '0},
    '{CMD_UPDATE, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_SELECT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_REPORT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_REPORT, 4'd15, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_UPDATE, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_SELECT, 4'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0}
  };

  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45)
        issue(CMD_REPORT, 4'($urandom_range(15)), ($urandom_range(3) != 0),
              ($urandom_range(7) == 0) ? $urandom_range(3) : $urandom(),
              ($urandom_range(7) == 0) ? 32'hFFFFFFFF >> $urandom_range(31) : $urandom(),
              1'b0, '0);
      else if (r < 65) issue(CMD_UPDATE, 4'($urandom()), 1'b0, 0, 0, 1'b0, '0);
      else if (r < 97) issue(CMD_SELECT, 4'($urandom()), 1'b0, 0, 0, 1'b0, '0);
      else issue(CMD_NOP, 4'($urandom()), 1'($urandom()), $urandom(), $urandom(), 1'b0, '0);
    end
  endtask

  initial begin
    errors = 0; cycle_count = 0; send_idle_pct = 0;
    rst_n = 0; start = 0; in_command = '0; in_receiver = '0; in_sendable = 0;
    in_credit_bytes = '0; in_unsent_bytes = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    mirror_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].rx, directed_rows[i].snd,
            directed_rows[i].cred, directed_rows[i].uns, directed_rows[i].has_fixed,
            directed_rows[i].fixed);
    drain();

    // settings: extremes, credit mode, random
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_FAIR_WEIGHT, 32'd65536); write_reg(REG_SRPT_WEIGHT, 32'd0);
                 write_reg(REG_PRIORITY_MODE, 32'd1); end
        1: begin write_reg(REG_FAIR_WEIGHT, 32'd0); write_reg(REG_SRPT_WEIGHT, 32'd65536); end
        2: begin write_reg(REG_FAIR_WEIGHT, 32'd0); write_reg(REG_SRPT_WEIGHT, 32'd0);
                 write_reg(REG_PRIORITY_MODE, 32'd0); end
        3: begin write_reg(REG_FAIR_WEIGHT, 32'd1); write_reg(REG_SRPT_WEIGHT, 32'd1); end
        default: begin
          write_reg(REG_FAIR_WEIGHT, $urandom_range(65536));
          write_reg(REG_SRPT_WEIGHT, $urandom_range(65536));
          write_reg(REG_PRIORITY_MODE, $urandom_range(1));
        end
      endcase
      send_idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 72 : 21;
      random_burst(phase == 2 ? 20 : 65);
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### filelist.f
rtl/core/hdsrpt_pkg.sv
rtl/core/hdsrpt_cell.sv
rtl/core/hdsrpt_div.sv
rtl/core/hybrid_deficit_srpt_scheduler.sv
bench/hybrid_deficit_srpt_scheduler_test.sv
